/* hdl/cpr_pkg.sv */
// ----------------------------------------------------------------------------
// cpr_pkg: shared types and constants for the clock page replacement block
// holds default sizes, request/outcome codes and the sequencer state type
// ----------------------------------------------------------------------------
package cpr_pkg;

  localparam int FRAMES_DEF = 256;
  localparam int PROCS_DEF  = 18;
  localparam int PAGES_DEF  = 32;

  localparam int REQ_W   = 2;
  localparam int SLOT_W  = 5;
  localparam int PAGE_W  = 5;
  localparam int OUT_W   = 2;
  localparam int FIDX_W  = 8;
  localparam int FREED_W = 9;

  localparam logic [REQ_W-1:0] REQ_READ  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_EXIT  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_UNDEF = 2'd3;

  localparam logic [OUT_W-1:0] OUT_HIT  = 2'd0;
  localparam logic [OUT_W-1:0] OUT_FILL = 2'd1;
  localparam logic [OUT_W-1:0] OUT_REPL = 2'd2;
  localparam logic [OUT_W-1:0] OUT_EXIT = 2'd3;

  typedef enum logic [3:0] {
    ST_CLEAR,     // clearing pass over both stores after reset
    ST_IDLE,
    ST_MAP_RD,    // page map read issued
    ST_MAP_CHK,
    ST_HIT_RD,    // frame read for a hit
    ST_HIT_WR,
    ST_FREE_RD,   // search for the lowest free frame
    ST_FREE_CHK,
    ST_SCAN_RD,   // clock scan
    ST_SCAN_CHK,
    ST_INSTALL,
    ST_EXIT_RD,   // sweep frames of an exiting process
    ST_EXIT_CHK,
    ST_EXIT_MAP,  // clear the process page table
    ST_RESULT
  } cpr_state_t;

endpackage

/* hdl/cpr_ram.sv */
// ----------------------------------------------------------------------------
// cpr_ram: generic single-port ram
// one write or read per cycle, registered read data
// ----------------------------------------------------------------------------
module cpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* hdl/clock_page_replacement.sv */
// ----------------------------------------------------------------------------
// clock_page_replacement: second-chance page replacement engine
// per-process page tables and a frame table walked by one sequencer
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one request word (req_type, process_slot, page_number);
//   m_axis returns one result word per request. one request is in work at a
//   time; s_axis_tready is low from acceptance until the result is taken.
// work per request, paced by the single frame-table port (each frame look
//   is a read state followed by a check state):
//   hit            map read, frame read, frame write setting the ref bit
//   free fill      map read, search up from frame 0 for the lowest free frame
//   replacement    full free search, clock scan from the hand, install
//   exit           sweep of every frame, then clear of the process page map
//   ignored words  go straight to the result
// reset: a clearing pass writes every frame and page-map entry to
//   free/invalid; s_axis_tready stays low.
// stall: a held result sits in the output register until m_axis_tready;
//   no new request is taken meanwhile.
// ----------------------------------------------------------------------------
module clock_page_replacement
  import cpr_pkg::*;
#(
  parameter int FRAMES = FRAMES_DEF,
  parameter int PROCS  = PROCS_DEF,
  parameter int PAGES  = PAGES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] req_type, [6:2] process_slot, [11:7] page_number, [15:12] zero
  input  logic [15:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] outcome, [9:2] frame_index, [14:10] victim_owner,
  // [19:15] victim_page, [20] victim_dirty, [29:21] frames_freed, [31:30] zero
  output logic [31:0] m_axis_tdata
);

  localparam int FA   = $clog2(FRAMES);
  localparam int MAPD = PROCS * PAGES;
  localparam int MA   = (MAPD > 1) ? $clog2(MAPD) : 1;
  localparam int CLRN = (MAPD > FRAMES) ? MAPD : FRAMES;
  localparam int CW   = $clog2(CLRN + 1);
  localparam int SW   = $clog2(2 * FRAMES + 2);
  localparam int NW   = $clog2(FRAMES + 1);
  // frame entry: {used, owner, page, ref, dirty}
  localparam int FEW  = 1 + SLOT_W + PAGE_W + 2;
  localparam int MEW  = 1 + FA;

  cpr_state_t state, state_next;

  logic [REQ_W-1:0]  req, req_next;
  logic [SLOT_W-1:0] slot, slot_next;
  logic [PAGE_W-1:0] page, page_next;
  logic [CW-1:0]     cnt, cnt_next;
  logic [SW-1:0]     scan, scan_next;
  logic [FA-1:0]     hand, hand_next;
  logic [FA-1:0]     fidx, fidx_next;
  logic [NW-1:0]     freed, freed_next;
  logic [OUT_W-1:0]  oc, oc_next;
  logic [SLOT_W-1:0] vo, vo_next;
  logic [PAGE_W-1:0] vp, vp_next;
  logic              vd, vd_next;
  logic              victim, victim_next;

  logic            f_we, m_we;
  logic [FA-1:0]   f_addr;
  logic [MA-1:0]   m_addr;
  logic [FEW-1:0]  f_wd, f_rd;
  logic [MEW-1:0]  m_wd, m_rd;

  cpr_ram #(.WIDTH(FEW), .DEPTH(FRAMES)) u_frames (
    .clk(clk), .we(f_we), .addr(f_addr), .wdata(f_wd), .rdata(f_rd)
  );
  cpr_ram #(.WIDTH(MEW), .DEPTH(MAPD)) u_map (
    .clk(clk), .we(m_we), .addr(m_addr), .wdata(m_wd), .rdata(m_rd)
  );

  logic              fr_used, fr_ref, fr_dirty;
  logic [SLOT_W-1:0] fr_owner;
  logic [PAGE_W-1:0] fr_page;
  assign {fr_used, fr_owner, fr_page, fr_ref, fr_dirty} = f_rd;

  logic [MA-1:0] map_self, map_vict;
  assign map_self = MA'(slot * PAGES + page);
  assign map_vict = MA'(vo * PAGES + vp);

  logic [FA-1:0] hand_inc;
  assign hand_inc = (fidx == FA'(FRAMES - 1)) ? '0 : fidx + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      cnt   <= '0;
      hand  <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      hand  <= hand_next;
    end
    req <= req_next; slot <= slot_next; page <= page_next;
    scan <= scan_next; fidx <= fidx_next; freed <= freed_next;
    oc <= oc_next; vo <= vo_next; vp <= vp_next; vd <= vd_next;
    victim <= victim_next;
  end

  always_comb begin
    state_next = state;
    req_next = req; slot_next = slot; page_next = page;
    cnt_next = cnt; scan_next = scan; hand_next = hand; fidx_next = fidx;
    freed_next = freed; oc_next = oc; vo_next = vo; vp_next = vp;
    vd_next = vd; victim_next = victim;
    f_we = 1'b0; f_addr = fidx; f_wd = '0;
    m_we = 1'b0; m_addr = map_self; m_wd = '0;
    case (state)
      ST_CLEAR: begin
        f_we = (cnt < CW'(FRAMES));
        f_addr = FA'(cnt);
        m_we = (cnt < CW'(MAPD));
        m_addr = MA'(cnt);
        cnt_next = cnt + 1'b1;
        if (cnt == CW'(CLRN - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          req_next  = s_axis_tdata[1:0];
          slot_next = s_axis_tdata[6:2];
          page_next = s_axis_tdata[11:7];
          oc_next = OUT_EXIT; fidx_next = '0; freed_next = '0;
          vo_next = '0; vp_next = '0; vd_next = 1'b0; victim_next = 1'b0;
          if (s_axis_tdata[1:0] == REQ_EXIT &&
              s_axis_tdata[6:2] < SLOT_W'(PROCS)) begin
            state_next = ST_EXIT_RD;
          end else if ((s_axis_tdata[1:0] == REQ_READ ||
                        s_axis_tdata[1:0] == REQ_WRITE) &&
                       s_axis_tdata[6:2] < SLOT_W'(PROCS) &&
                       32'(s_axis_tdata[11:7]) < PAGES) begin
            state_next = ST_MAP_RD;
          end else begin
            state_next = ST_RESULT;
          end
        end
      end
      ST_MAP_RD: state_next = ST_MAP_CHK;
      ST_MAP_CHK: begin
        if (m_rd[MEW-1]) begin
          fidx_next = m_rd[FA-1:0];
          state_next = ST_HIT_RD;
        end else begin
          fidx_next = '0;
          state_next = ST_FREE_RD;
        end
      end
      ST_HIT_RD: state_next = ST_HIT_WR;
      ST_HIT_WR: begin
        f_we = 1'b1;
        f_wd = {fr_used, fr_owner, fr_page, 1'b1, fr_dirty | (req == REQ_WRITE)};
        oc_next = OUT_HIT;
        state_next = ST_RESULT;
      end
      ST_FREE_RD: state_next = ST_FREE_CHK;
      ST_FREE_CHK: begin
        if (!fr_used) begin
          oc_next = OUT_FILL;
          state_next = ST_INSTALL;
        end else if (fidx == FA'(FRAMES - 1)) begin
          fidx_next = hand;
          scan_next = '0;
          state_next = ST_SCAN_RD;
        end else begin
          fidx_next = fidx + 1'b1;
          state_next = ST_FREE_RD;
        end
      end
      ST_SCAN_RD: state_next = ST_SCAN_CHK;
      ST_SCAN_CHK: begin
        if (fr_ref && scan != SW'(2 * FRAMES)) begin
          f_we = 1'b1;
          f_wd = {fr_used, fr_owner, fr_page, 1'b0, fr_dirty};
          fidx_next = hand_inc;
          scan_next = scan + 1'b1;
          state_next = ST_SCAN_RD;
        end else begin
          vo_next = fr_owner; vp_next = fr_page; vd_next = fr_dirty;
          victim_next = (fr_owner < SLOT_W'(PROCS)) && (32'(fr_page) < PAGES);
          oc_next = OUT_REPL;
          state_next = ST_INSTALL;
        end
      end
      ST_INSTALL: begin
        // invalidate victim mapping first, then the new mapping overrides
        if (victim) begin
          m_we = 1'b1;
          m_addr = map_vict;
          m_wd = '0;
          victim_next = 1'b0;
        end else begin
          m_we = 1'b1;
          m_wd = {1'b1, fidx};
          f_we = 1'b1;
          f_wd = {1'b1, slot, page, 1'b0, req == REQ_WRITE};
          hand_next = hand_inc;
          state_next = ST_RESULT;
        end
      end
      ST_EXIT_RD: state_next = ST_EXIT_CHK;
      ST_EXIT_CHK: begin
        if (fr_used && fr_owner == slot) begin
          f_we = 1'b1;
          f_wd = '0;
          freed_next = freed + 1'b1;
        end
        if (fidx == FA'(FRAMES - 1)) begin
          cnt_next = '0;
          state_next = ST_EXIT_MAP;
        end else begin
          fidx_next = fidx + 1'b1;
          state_next = ST_EXIT_RD;
        end
      end
      ST_EXIT_MAP: begin
        m_we = 1'b1;
        m_addr = MA'(slot * PAGES + 32'(cnt));
        cnt_next = cnt + 1'b1;
        if (cnt == CW'(PAGES - 1)) begin
          fidx_next = '0;
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (m_axis_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = (state == ST_RESULT);
  assign m_axis_tdata  = {2'b00, FREED_W'(freed), vd, vp, vo, FIDX_W'(fidx), oc};

endmodule
